/* hw/rtl/ttce_pkg.sv */
// Shared constants, codes and types of the text terminal cell engine.
`timescale 1ns / 1ps

package ttce_pkg;

  // Screen geometry.
  localparam int COLUMNS = 50;
  localparam int ROWS    = 16;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int COPY_N  = CELLS - COLUMNS;

  // Internal widths derived from the geometry.
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int CNT_W  = $clog2(COLUMNS + 1);
  localparam int ROW_W  = $clog2(ROWS + 1);
  localparam int CELL_W = 16;

  // Bytes with a meaning of their own.
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_UP       = 8'h41;
  localparam logic [7:0] CH_DOWN     = 8'h42;
  localparam logic [7:0] CH_RIGHT    = 8'h43;
  localparam logic [7:0] CH_LEFT     = 8'h44;
  localparam logic [7:0] CH_ERASE    = 8'h4B;

  localparam logic [CELL_W-1:0] CELL_SPACE       = 16'h0020;
  localparam logic [CELL_W-1:0] CELL_REPLACEMENT = 16'hFFFD;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_MARK  = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ESC_NONE    = 2'd0,
    ESC_START   = 2'd1,
    ESC_BRACKET = 2'd2,
    ESC_DIGITS  = 2'd3
  } esc_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_ERASE,
    S_SCROLL,
    S_GAP,
    S_FILL,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    PK_COPY,
    PK_ZERO,
    PK_FILL
  } pend_t;

endpackage

/* hw/rtl/ttce_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module ttce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 800
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Synchronous write; the read data is registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/text_terminal_cell_engine_top.sv */
// Top level of the text terminal cell engine: byte interpreter, sequencer and cell store.
`timescale 1ns / 1ps
//
// Character-cell terminal engine. Each input transaction carries an action
// (put byte, read cell, clear dirty range, mark all rows dirty), a byte and a
// cell address; each one produces exactly one output transaction with the read
// cell, the cursor position, the dirty row range and a scroll flag.
// Both channels use valid/ready. The cell store is one RAM with a registered
// read port; a sequencer reads, modifies and writes it back.
// Reads, dirty actions and ordinary bytes pass from decode straight to the
// final state. An erase in line then writes the erased cells one by one (up to
// COLUMNS). A jump then walks the cells before the cursor in its row for the
// blank fill. A scroll walks all CELLS cells for the row copy and the clearing
// of the last row, followed by the fill of the cursor row. The sequencer
// handles one transaction at a time and takes a new one only after the last
// has reached the output; the scroll walk over the RAM port sets the worst case.
// After reset the block sweeps the store to zero, one cell per cycle, over
// all CELLS = 800 cells, with in_ready low. A finished result sits in the output
// register; the next transaction is accepted while it waits, and the
// sequencer holds in its final state until the register frees up.

module text_terminal_cell_engine_top
  import ttce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  byte_in,
  input  logic [9:0]  cell_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] cell_data,
  output logic [5:0]  cursor_column,
  output logic [3:0]  cursor_row,
  output logic [4:0]  dirty_first,
  output logic [4:0]  dirty_end,
  output logic        scrolled
);

  state_t state, state_next;
  logic [ADDR_W-1:0] clr_cnt, clr_cnt_next;
  logic [ADDR_W-1:0] walk_cnt, walk_cnt_next;
  logic [COL_W-1:0] col_cnt, col_cnt_next;
  logic [CNT_W-1:0] erase_hi, erase_hi_next;
  act_t act, act_next;
  logic [7:0] byt, byt_next;
  logic oob, oob_next;
  logic [ROW_W-1:0] cur_row, cur_row_next;
  logic [COL_W-1:0] cur_col, cur_col_next;
  logic [3:0] u_shift, u_shift_next;
  esc_t esc_st, esc_st_next;
  logic [15:0] esc_cnt, esc_cnt_next;
  logic [ROW_W-1:0] d_first, d_first_next;
  logic [ROW_W-1:0] d_end, d_end_next;
  logic [CELL_W-1:0] res_data, res_data_next;
  logic scr_flag, scr_flag_next;
  logic pend_valid, pend_valid_next;
  logic [ADDR_W-1:0] pend_addr, pend_addr_next;
  pend_t pend_kind, pend_kind_next;
  logic load_out;

  logic ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;
  logic direct_we;

  logic [ADDR_W-1:0] row_base, cur_addr;

  assign row_base = ADDR_W'(cur_row) * ADDR_W'(COLUMNS);
  assign cur_addr = row_base + ADDR_W'(cur_col);

  // Cell store.
  ttce_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Sequencer: next state, RAM port control and the byte interpreter.
  always_comb begin
    logic [ROW_W-1:0] row_t;
    logic [COL_W-1:0] col_t;
    logic [15:0] n;
    logic [19:0] dec_sum;
    logic jump;
    logic do_scroll;
    logic do_erase;
    logic [ROW_W-1:0] row_lim;
    logic [COL_W-1:0] col_lim;

    state_next     = state;
    clr_cnt_next   = clr_cnt;
    walk_cnt_next  = walk_cnt;
    col_cnt_next   = col_cnt;
    erase_hi_next  = erase_hi;
    act_next       = act;
    byt_next       = byt;
    oob_next       = oob;
    cur_row_next   = cur_row;
    cur_col_next   = cur_col;
    u_shift_next   = u_shift;
    esc_st_next    = esc_st;
    esc_cnt_next   = esc_cnt;
    d_first_next   = d_first;
    d_end_next     = d_end;
    res_data_next  = res_data;
    scr_flag_next  = scr_flag;
    pend_valid_next = 1'b0;
    pend_addr_next = pend_addr;
    pend_kind_next = pend_kind;
    load_out       = 1'b0;
    in_ready       = 1'b0;
    direct_we      = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = cur_addr;
    ram_wdata      = '0;
    ram_raddr      = cur_addr;
    row_t          = cur_row;
    col_t          = cur_col;
    n              = esc_cnt;
    dec_sum        = '0;
    jump           = 1'b0;
    do_scroll      = 1'b0;
    do_erase       = 1'b0;
    row_lim        = ROW_W'(ROWS - 1) - cur_row;
    col_lim        = COL_W'(COLUMNS - 1) - cur_col;

    // Write-back of a cell read in the previous cycle.
    if (pend_valid) begin
      ram_waddr = pend_addr;
      case (pend_kind)
        PK_COPY: begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
        end
        PK_ZERO: begin
          ram_we    = 1'b1;
          ram_wdata = '0;
        end
        default: begin
          ram_we    = (ram_rdata == '0);
          ram_wdata = CELL_SPACE;
        end
      endcase
    end

    unique case (state)
      S_CLEAR: begin
        direct_we     = 1'b1;
        ram_we        = 1'b1;
        ram_waddr     = clr_cnt;
        ram_wdata     = '0;
        clr_cnt_next  = clr_cnt + 1'b1;
        if (clr_cnt == ADDR_W'(CELLS - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready = 1'b1;
        if (act_t'(action) == ACT_READ) begin
          ram_raddr = (cell_address >= 10'(CELLS)) ? '0 : ADDR_W'(cell_address);
        end
        if (in_valid) begin
          act_next   = act_t'(action);
          byt_next   = byte_in;
          oob_next   = (cell_address >= 10'(CELLS));
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        res_data_next = '0;
        scr_flag_next = 1'b0;
        unique case (act)
          ACT_READ: begin
            res_data_next = oob ? '0 : ram_rdata;
          end
          ACT_CLEAR: begin
            d_first_next = '0;
            d_end_next   = '0;
          end
          ACT_MARK: begin
            d_first_next = '0;
            d_end_next   = ROW_W'(ROWS);
          end
          ACT_PUT: begin
            if (esc_st == ESC_NONE) begin
              if (!byt[7]) begin
                if (byt == CH_BS) begin
                  if (cur_row != '0 || cur_col != '0) begin
                    if (cur_col == '0) begin
                      row_t = cur_row - 1'b1;
                      col_t = COL_W'(COLUMNS - 1);
                    end else begin
                      col_t = cur_col - 1'b1;
                    end
                  end
                end else if (byt == CH_ESC) begin
                  esc_st_next = ESC_START;
                end else if (byt == CH_LF) begin
                  row_t = cur_row + 1'b1;
                  jump  = 1'b1;
                end else if (byt == CH_CR) begin
                  col_t = '0;
                end else begin
                  direct_we = 1'b1;
                  ram_we    = 1'b1;
                  ram_wdata = CELL_W'(byt);
                  if (cur_col == COL_W'(COLUMNS - 1)) begin
                    col_t = '0;
                    row_t = cur_row + 1'b1;
                  end else begin
                    col_t = cur_col + 1'b1;
                  end
                end
              end else if (!byt[6]) begin
                // Continuation byte merges into the cell at the cursor.
                direct_we = 1'b1;
                ram_we    = 1'b1;
                ram_wdata = ram_rdata | (CELL_W'(byt[5:0]) << u_shift);
                if (u_shift == '0) begin
                  if (cur_col == COL_W'(COLUMNS - 1)) begin
                    col_t = '0;
                    row_t = cur_row + 1'b1;
                  end else begin
                    col_t = cur_col + 1'b1;
                  end
                end else begin
                  u_shift_next = (u_shift >= 4'd6) ? u_shift - 4'd6 : 4'd0;
                end
              end else if (!byt[5]) begin
                direct_we    = 1'b1;
                ram_we       = 1'b1;
                ram_wdata    = CELL_W'(byt[4:0]) << 6;
                u_shift_next = 4'd0;
              end else if (!byt[4]) begin
                direct_we    = 1'b1;
                ram_we       = 1'b1;
                ram_wdata    = CELL_W'(byt[3:0]) << 12;
                u_shift_next = 4'd6;
              end else if (!byt[3]) begin
                direct_we    = 1'b1;
                ram_we       = 1'b1;
                ram_wdata    = '0;
                u_shift_next = 4'd12;
              end else begin
                direct_we = 1'b1;
                ram_we    = 1'b1;
                ram_wdata = CELL_REPLACEMENT;
                if (cur_col == COL_W'(COLUMNS - 1)) begin
                  col_t = '0;
                  row_t = cur_row + 1'b1;
                end else begin
                  col_t = cur_col + 1'b1;
                end
              end
            end else if (esc_st == ESC_START) begin
              if (byt == CH_LBRACKET) begin
                esc_cnt_next = '0;
                esc_st_next  = ESC_BRACKET;
              end else begin
                esc_st_next = ESC_NONE;
              end
            end else if (byt >= CH_ZERO && byt <= CH_NINE) begin
              // Decimal accumulation with saturation.
              dec_sum = {4'd0, esc_cnt} * 20'd10 + 20'(byt[3:0]);
              esc_cnt_next = (|dec_sum[19:16]) ? 16'hFFFF : dec_sum[15:0];
              esc_st_next  = ESC_DIGITS;
            end else begin
              // Final byte of a control sequence.
              if (esc_st == ESC_BRACKET) begin
                n = (byt == CH_ERASE) ? 16'd0 : 16'd1;
              end
              esc_cnt_next = '0;
              esc_st_next  = ESC_NONE;
              if (byt == CH_UP) begin
                row_t = (n < 16'(cur_row)) ? cur_row - ROW_W'(n) : '0;
                jump  = (n != '0) && (cur_row != '0);
              end else if (byt == CH_DOWN) begin
                row_t = (n < 16'(row_lim)) ? cur_row + ROW_W'(n) : ROW_W'(ROWS - 1);
                jump  = (n != '0) && (row_lim != '0);
              end else if (byt == CH_RIGHT) begin
                col_t = (n < 16'(col_lim)) ? cur_col + COL_W'(n) : COL_W'(COLUMNS - 1);
                jump  = (n != '0) && (col_lim != '0);
              end else if (byt == CH_LEFT) begin
                col_t = (n < 16'(cur_col)) ? cur_col - COL_W'(n) : '0;
              end else if (byt == CH_ERASE) begin
                do_erase = (n == 16'd0) || (n == 16'd2) ||
                           ((n == 16'd1) && (cur_col != '0));
                col_cnt_next  = (n == 16'd0) ? cur_col : '0;
                erase_hi_next = (n == 16'd1) ? CNT_W'(cur_col) : CNT_W'(COLUMNS);
              end
            end

            // Scroll when the cursor ran past the last row, else track dirty rows.
            if (row_t == ROW_W'(ROWS)) begin
              row_t         = ROW_W'(ROWS - 1);
              do_scroll     = 1'b1;
              jump          = 1'b1;
              scr_flag_next = 1'b1;
              d_first_next  = '0;
              d_end_next    = ROW_W'(ROWS);
            end else if (d_first == d_end) begin
              d_first_next = row_t;
              d_end_next   = row_t + 1'b1;
            end else begin
              if (d_first > row_t) d_first_next = row_t;
              if (d_end < row_t + 1'b1) d_end_next = row_t + 1'b1;
            end
          end
        endcase

        cur_row_next = row_t;
        cur_col_next = col_t;
        if (do_scroll) begin
          walk_cnt_next = '0;
          state_next    = S_SCROLL;
        end else if (do_erase) begin
          state_next = S_ERASE;
        end else if (jump && col_t != '0) begin
          col_cnt_next = col_t - 1'b1;
          state_next   = S_FILL;
        end else begin
          state_next = S_DONE;
        end
      end

      S_ERASE: begin
        direct_we    = 1'b1;
        ram_we       = 1'b1;
        ram_waddr    = row_base + ADDR_W'(col_cnt);
        ram_wdata    = (col_cnt < cur_col) ? CELL_SPACE : '0;
        col_cnt_next = col_cnt + 1'b1;
        if (CNT_W'(col_cnt) + 1'b1 == erase_hi) begin
          state_next = S_DONE;
        end
      end

      S_SCROLL: begin
        // Read the cell one row down and write it one row up in the next cycle; the last row is cleared instead.
        ram_raddr       = walk_cnt + ADDR_W'(COLUMNS);
        pend_valid_next = 1'b1;
        pend_addr_next  = walk_cnt;
        pend_kind_next  = (walk_cnt < ADDR_W'(COPY_N)) ? PK_COPY : PK_ZERO;
        walk_cnt_next   = walk_cnt + 1'b1;
        if (walk_cnt == ADDR_W'(CELLS - 1)) begin
          state_next = S_GAP;
        end
      end

      S_GAP: begin
        if (cur_col != '0) begin
          col_cnt_next = cur_col - 1'b1;
          state_next   = S_FILL;
        end else begin
          state_next = S_DONE;
        end
      end

      S_FILL: begin
        ram_raddr       = row_base + ADDR_W'(col_cnt);
        pend_valid_next = 1'b1;
        pend_addr_next  = row_base + ADDR_W'(col_cnt);
        pend_kind_next  = PK_FILL;
        col_cnt_next    = col_cnt - 1'b1;
        if (col_cnt == '0) begin
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      cur_row    <= '0;
      cur_col    <= '0;
      u_shift    <= '0;
      esc_st     <= ESC_NONE;
      esc_cnt    <= '0;
      d_first    <= '0;
      d_end      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      clr_cnt    <= clr_cnt_next;
      cur_row    <= cur_row_next;
      cur_col    <= cur_col_next;
      u_shift    <= u_shift_next;
      esc_st     <= esc_st_next;
      esc_cnt    <= esc_cnt_next;
      d_first    <= d_first_next;
      d_end      <= d_end_next;
      pend_valid <= pend_valid_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers and the output register.
  always_ff @(posedge clk) begin
    walk_cnt  <= walk_cnt_next;
    col_cnt   <= col_cnt_next;
    erase_hi  <= erase_hi_next;
    act       <= act_next;
    byt       <= byt_next;
    oob       <= oob_next;
    res_data  <= res_data_next;
    scr_flag  <= scr_flag_next;
    pend_addr <= pend_addr_next;
    pend_kind <= pend_kind_next;
    if (load_out) begin
      cell_data     <= res_data;
      cursor_column <= 6'(cur_col);
      cursor_row    <= 4'(cur_row);
      dirty_first   <= 5'(d_first);
      dirty_end     <= 5'(d_end);
      scrolled      <= scr_flag;
    end
  end

  // A delayed write-back never collides with a direct write.
  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    !(pend_valid && direct_we))
    else $error("delayed write-back collides with a direct cell write");

  // An accepted transaction is decoded in the next cycle.
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DECODE))
    else $error("accepted transaction not decoded");

  // The cursor row stays on the screen between transactions.
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (cur_row < ROW_W'(ROWS)))
    else $error("cursor row off screen");

  // The dirty range is ordered whenever a result is offered.
  a_dirty_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (dirty_first <= dirty_end))
    else $error("dirty range out of order");

endmodule
